// ----- design/lrde_pkg.sv -----
// ----------------------------------------------------------------------------
// lrde_pkg: shared types and constants of the expression evaluator
// Character codes, operator codes, the microcode word format and the
// microprogram that drives the evaluator datapath.
// ----------------------------------------------------------------------------
package lrde_pkg;

	// Character codes of the expression stream
	localparam logic [7:0] CHR_NUL   = 8'd0;
	localparam logic [7:0] CHR_MUL   = 8'd42;
	localparam logic [7:0] CHR_PLUS  = 8'd43;
	localparam logic [7:0] CHR_MINUS = 8'd45;
	localparam logic [7:0] CHR_DIV   = 8'd47;
	localparam logic [7:0] CHR_ZERO  = 8'd48;

	// Width of a result value on the output channel
	localparam int ResultW = 32;

	// Pending operator codes
	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// Datapath action selected by a microcode word
	typedef enum logic [3:0] {
		DP_NONE,
		DP_FETCH,
		DP_ADDSUB,
		DP_MUL_LOAD,
		DP_MUL_STEP,
		DP_MUL_DONE,
		DP_DIV_LOAD,
		DP_DIV_STEP,
		DP_DIV_DONE,
		DP_FINISH,
		DP_EMIT
	} dp_t;

	// Next-address condition of a microcode word
	typedef enum logic [2:0] {
		CND_NEXT,      // step + 1
		CND_GOTO,      // target
		CND_DISPATCH,  // wait for a non-digit character, then branch on the pending operator
		CND_LOOP,      // repeat until the bit counter runs out, then step + 1
		CND_IF_ZERO,   // target when the operand is zero, else step + 1
		CND_IF_MORE,   // target when the character was not NUL, else step + 1
		CND_WAIT_OUT   // hold until the output register is free, then target
	} cond_t;

	typedef logic [3:0] upc_t;

	// Microprogram addresses
	localparam upc_t UA_FETCH    = 4'd0;
	localparam upc_t UA_ADDSUB   = 4'd1;
	localparam upc_t UA_MUL_INIT = 4'd2;
	localparam upc_t UA_MUL_STEP = 4'd3;
	localparam upc_t UA_MUL_DONE = 4'd4;
	localparam upc_t UA_DIV_INIT = 4'd5;
	localparam upc_t UA_DIV_STEP = 4'd6;
	localparam upc_t UA_DIV_DONE = 4'd7;
	localparam upc_t UA_FINISH   = 4'd8;
	localparam upc_t UA_EMIT     = 4'd9;

	// One control word
	typedef struct packed {
		logic  ready;
		dp_t   dp;
		cond_t cond;
		upc_t  target;
	} ucode_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic accept;     // character transaction this cycle
		logic is_digit;   // incoming character is a digit
		op_t  op;         // pending operator
		logic cnt_last;   // last bit step of multiply or divide
		logic num_zero;   // right operand is zero
		logic more;       // latched character was not NUL
		logic out_free;   // output register can take a result
	} seq_status_t;

	// Microprogram ROM
	function automatic ucode_t lrde_ucode(upc_t addr);
		ucode_t w;
		case (addr)
			UA_FETCH:    w = '{1'b1, DP_FETCH,    CND_DISPATCH, UA_FETCH};
			UA_ADDSUB:   w = '{1'b0, DP_ADDSUB,   CND_GOTO,     UA_FINISH};
			UA_MUL_INIT: w = '{1'b0, DP_MUL_LOAD, CND_NEXT,     UA_FETCH};
			UA_MUL_STEP: w = '{1'b0, DP_MUL_STEP, CND_LOOP,     UA_FETCH};
			UA_MUL_DONE: w = '{1'b0, DP_MUL_DONE, CND_GOTO,     UA_FINISH};
			UA_DIV_INIT: w = '{1'b0, DP_DIV_LOAD, CND_IF_ZERO,  UA_FINISH};
			UA_DIV_STEP: w = '{1'b0, DP_DIV_STEP, CND_LOOP,     UA_FETCH};
			UA_DIV_DONE: w = '{1'b0, DP_DIV_DONE, CND_NEXT,     UA_FETCH};
			UA_FINISH:   w = '{1'b0, DP_FINISH,   CND_IF_MORE,  UA_FETCH};
			UA_EMIT:     w = '{1'b0, DP_EMIT,     CND_WAIT_OUT, UA_FETCH};
			default:     w = '{1'b0, DP_NONE,     CND_GOTO,     UA_FETCH};
		endcase
		return w;
	endfunction

	// Map an operator or NUL character to the next pending operator
	function automatic op_t char_to_op(logic [7:0] c);
		op_t op;
		case (c)
			CHR_MINUS: op = OP_SUB;
			CHR_MUL:   op = OP_MUL;
			CHR_DIV:   op = OP_DIV;
			default:   op = OP_ADD;
		endcase
		return op;
	endfunction

endpackage

// ----- design/lrde_if.sv -----
// ----------------------------------------------------------------------------
// lrde_if: stream channels of the expression evaluator
// Valid/ready channels for expression characters and for results.
// ----------------------------------------------------------------------------
interface lrde_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface lrde_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic               div_by_zero;

	modport source (output valid, output value, output div_by_zero, input ready);
	modport sink (input valid, input value, input div_by_zero, output ready);
endinterface

// ----- design/lrde_sequencer.sv -----
// ----------------------------------------------------------------------------
// lrde_sequencer: microprogram sequencer
// Holds the step counter, reads the control word from the microcode ROM and
// picks the next step from the datapath status.
// ----------------------------------------------------------------------------
module lrde_sequencer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lrde_pkg::seq_status_t    status,
	output lrde_pkg::ucode_t         ctl
);
	import lrde_pkg::*;

	upc_t upc_q;
	upc_t upc_d;
	upc_t upc_inc;

	// Decode the current step
	assign ctl     = lrde_ucode(upc_q);
	assign upc_inc = upc_t'(upc_q + 1'b1);

	// Pick the next step
	always_comb begin
		upc_d = upc_q;
		case (ctl.cond)
			CND_NEXT: upc_d = upc_inc;
			CND_GOTO: upc_d = ctl.target;
			CND_DISPATCH: begin
				if (status.accept && !status.is_digit) begin
					case (status.op)
						OP_MUL:  upc_d = UA_MUL_INIT;
						OP_DIV:  upc_d = UA_DIV_INIT;
						default: upc_d = UA_ADDSUB;
					endcase
				end
			end
			CND_LOOP: begin
				if (status.cnt_last) begin
					upc_d = upc_inc;
				end
			end
			CND_IF_ZERO: upc_d = status.num_zero ? ctl.target : upc_inc;
			CND_IF_MORE: upc_d = status.more ? ctl.target : upc_inc;
			CND_WAIT_OUT: begin
				if (status.out_free) begin
					upc_d = ctl.target;
				end
			end
			default: upc_d = UA_FETCH;
		endcase
	end

	// Hold the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UA_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ----- design/left_to_right_decimal_expression_eval_top.sv -----
// ----------------------------------------------------------------------------
// left_to_right_decimal_expression_eval_top: streaming expression evaluator
// Evaluates +, -, * and / strictly left to right over a character stream.
// ----------------------------------------------------------------------------
// The block takes one character per transaction and evaluates the expression
// left to right with no precedence, in DATA_WIDTH-bit two's complement with
// wraparound; NUL ends the expression and emits one result whose value is
// the accumulator sign-extended to 32 bits, with a flag for any division by
// zero. A digit character is taken in the fetch step. An operator or NUL that
// closes an addition or subtraction passes through the add/sub and finish
// steps; one that closes a multiplication or division passes through a load
// step, the bit loop of the shared shift-add / restoring-divide unit that
// retires one operand bit per cycle, a done step and the finish step. A
// division by zero skips the bit loop and the done step. NUL adds an emit
// step to load the output register, and waits there while a previous result
// has not been taken. A finished result waits in its own register while the next expression streams in.
// ----------------------------------------------------------------------------
module left_to_right_decimal_expression_eval_top #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	lrde_char_if.sink            chars,
	lrde_result_if.source        results
);
	import lrde_pkg::*;

	localparam int DW   = DATA_WIDTH;
	localparam int CntW = $clog2(DW);

	ucode_t      ctl;
	seq_status_t status;

	// Architectural state
	logic [DW-1:0] acc_q;
	logic [DW-1:0] num_q;
	op_t           op_q;
	logic          err_q;

	// Shared multiply / divide unit
	logic [DW-1:0]   a_q;
	logic [DW-1:0]   b_q;
	logic [DW-1:0]   p_q;
	logic [CntW-1:0] cnt_q;
	logic            neg_q;
	logic [7:0]      char_q;

	// Output register
	logic                     out_valid_q;
	logic signed [ResultW-1:0] out_value_q;
	logic                     out_dz_q;

	logic          accept;
	logic          is_digit;
	logic          num_zero;
	logic          out_free;
	logic          emit_fire;
	logic [DW-1:0] digit_num;
	logic [DW-1:0] acc_mag;
	logic [DW-1:0] num_mag;
	logic [DW:0]   div_shift;
	logic [DW:0]   div_diff;

	lrde_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctl    (ctl)
	);

	// Classify the incoming character and gather status
	always_comb begin
		accept    = chars.valid && chars.ready;
		is_digit  = !(chars.char_code inside {CHR_NUL, CHR_PLUS, CHR_MINUS, CHR_MUL, CHR_DIV});
		num_zero  = (num_q == '0);
		out_free  = !out_valid_q || results.ready;
		emit_fire = (ctl.dp == DP_EMIT) && out_free;

		status.accept   = accept;
		status.is_digit = is_digit;
		status.op       = op_q;
		status.cnt_last = (cnt_q == '0);
		status.num_zero = num_zero;
		status.more     = (char_q != CHR_NUL);
		status.out_free = out_free;
	end

	// Datapath arithmetic
	always_comb begin
		// number * 10 + (code - 48), as (n << 3) + (n << 1) + digit
		digit_num = (num_q << 3) + (num_q << 1) + DW'(chars.char_code) - DW'(CHR_ZERO);
		acc_mag   = acc_q[DW-1] ? (~acc_q + 1'b1) : acc_q;
		num_mag   = num_q[DW-1] ? (~num_q + 1'b1) : num_q;
		div_shift = {p_q, a_q[DW-1]};
		div_diff  = div_shift - {1'b0, b_q};
	end

	assign chars.ready         = ctl.ready;
	assign results.valid       = out_valid_q;
	assign results.value       = out_value_q;
	assign results.div_by_zero = out_dz_q;

	// Update architectural state and the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			num_q       <= '0;
			op_q        <= OP_ADD;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (ctl.dp)
				DP_FETCH: begin
					if (accept && is_digit) begin
						num_q <= digit_num;
					end
				end
				DP_ADDSUB: acc_q <= (op_q == OP_SUB) ? (acc_q - num_q) : (acc_q + num_q);
				DP_MUL_DONE: acc_q <= p_q;
				DP_DIV_LOAD: begin
					if (num_zero) begin
						acc_q <= '0;
						err_q <= 1'b1;
					end
				end
				DP_DIV_DONE: acc_q <= neg_q ? (~a_q + 1'b1) : a_q;
				DP_FINISH: begin
					num_q <= '0;
					op_q  <= char_to_op(char_q);
				end
				DP_EMIT: begin
					if (out_free) begin
						acc_q <= '0;
						err_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// Advance the multiply / divide unit and load the result payload
	always_ff @(posedge clk) begin
		case (ctl.dp)
			DP_FETCH: begin
				if (accept) begin
					char_q <= chars.char_code;
				end
			end
			DP_MUL_LOAD: begin
				p_q   <= '0;
				a_q   <= acc_q;
				b_q   <= num_q;
				cnt_q <= CntW'(DW - 1);
			end
			DP_MUL_STEP: begin
				if (b_q[0]) begin
					p_q <= p_q + a_q;
				end
				a_q   <= a_q << 1;
				b_q   <= b_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			DP_DIV_LOAD: begin
				p_q   <= '0;
				a_q   <= acc_mag;
				b_q   <= num_mag;
				neg_q <= acc_q[DW-1] ^ num_q[DW-1];
				cnt_q <= CntW'(DW - 1);
			end
			DP_DIV_STEP: begin
				// Restoring step: subtract when the divisor fits
				if (!div_diff[DW]) begin
					p_q <= div_diff[DW-1:0];
					a_q <= {a_q[DW-2:0], 1'b1};
				end else begin
					p_q <= div_shift[DW-1:0];
					a_q <= {a_q[DW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
			end
			DP_EMIT: begin
				if (out_free) begin
					out_value_q <= ResultW'($signed(acc_q));
					out_dz_q    <= err_q;
				end
			end
			default: ;
		endcase
	end

	// No new character while the shared unit is iterating
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.dp == DP_MUL_STEP || ctl.dp == DP_DIV_STEP) |-> !chars.ready)
		else $error("character accepted during multiply or divide");

	// A new result appears only out of the emit step
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(emit_fire))
		else $error("result raised outside the emit step");

	// Emitting a result returns the state to its reset values
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |=> (acc_q == '0 && num_q == '0 && !err_q && op_q == OP_ADD))
		else $error("state not cleared after emit");

	// A zero divisor marks the error flag
	a_div_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.dp == DP_DIV_LOAD && num_zero) |=> (err_q && acc_q == '0))
		else $error("division by zero not flagged");

endmodule

// ----- sim/tb_left_to_right_decimal_expression_eval_top.sv -----
// ----------------------------------------------------------------------------
// tb_left_to_right_decimal_expression_eval_top: expression evaluator testbench
// Streams expression characters into the evaluator and checks every emitted
// result against a cycle-free evaluator kept alongside. It covers directed
// corner expressions, random well-formed and broken expressions, gaps on
// both channels and a long output stall that backs up the character input.
// ----------------------------------------------------------------------------
module tb_left_to_right_decimal_expression_eval_top;
	import lrde_pkg::*;

	localparam int DataW       = 32;
	localparam int CycleLimit  = 500000;
	localparam int DrainCycles = 64;
	localparam int HoldCycles  = 600;

	typedef struct {
		logic signed [31:0] value;
		logic               div_by_zero;
	} result_t;

	logic clk = 1'b0;
	logic arst_n;

	lrde_char_if   chars_if ();
	lrde_result_if results_if ();

	left_to_right_decimal_expression_eval_top #(
		.DATA_WIDTH(DataW)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.results(results_if)
	);

	// Evaluator state mirrored from the character stream
	logic [DataW-1:0] eval_acc;
	logic [DataW-1:0] eval_num;
	op_t              eval_op;
	logic             eval_err;
	result_t          expected_results[$];

	int  error_count = 0;
	int  chars_sent  = 0;
	int  cycle_count = 0;
	int  hold_left   = 0;
	bit  tx_idle     = 1'b1;
	bit  rx_idle     = 1'b1;
	event hold_start;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Count down the long output hold-off once it is requested
	initial begin
		forever begin
			@(hold_start);
			hold_left <= HoldCycles;
			@(posedge clk);
			while (hold_left != 0) begin
				hold_left <= hold_left - 1;
				@(posedge clk);
			end
		end
	end

	function automatic logic [DataW-1:0] div_trunc(logic [DataW-1:0] a, logic [DataW-1:0] b);
		logic [DataW-1:0] mag_a;
		logic [DataW-1:0] mag_b;
		logic [DataW-1:0] quo;
		mag_a = a[DataW-1] ? -a : a;
		mag_b = b[DataW-1] ? -b : b;
		quo   = mag_a / mag_b;
		return (a[DataW-1] ^ b[DataW-1]) ? -quo : quo;
	endfunction

	// Fold the current number into the accumulator with the pending operator
	function automatic void eval_apply();
		case (eval_op)
			OP_ADD: eval_acc = eval_acc + eval_num;
			OP_SUB: eval_acc = eval_acc - eval_num;
			OP_MUL: eval_acc = eval_acc * eval_num;
			OP_DIV: begin
				if (eval_num == '0) begin
					eval_acc = '0;
					eval_err = 1'b1;
				end else begin
					eval_acc = div_trunc(eval_acc, eval_num);
				end
			end
			default: ;
		endcase
		eval_num = '0;
	endfunction

	function automatic void eval_clear();
		eval_acc = '0;
		eval_num = '0;
		eval_op  = OP_ADD;
		eval_err = 1'b0;
	endfunction

	// Advance the evaluator by one accepted character
	function automatic void eval_char(logic [7:0] c);
		result_t res;
		case (c)
			CHR_PLUS: begin
				eval_apply();
				eval_op = OP_ADD;
			end
			CHR_MINUS: begin
				eval_apply();
				eval_op = OP_SUB;
			end
			CHR_MUL: begin
				eval_apply();
				eval_op = OP_MUL;
			end
			CHR_DIV: begin
				eval_apply();
				eval_op = OP_DIV;
			end
			CHR_NUL: begin
				eval_apply();
				res.value       = 32'(signed'(eval_acc));
				res.div_by_zero = eval_err;
				expected_results.push_back(res);
				eval_clear();
			end
			default: begin
				eval_num = eval_num * DataW'(10) + (DataW'(c) - DataW'(CHR_ZERO));
			end
		endcase
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	// Offer one character and hold it until the transaction completes
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		repeat (gap) begin
			chars_if.valid <= 1'b0;
			@(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= c;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		eval_char(c);
		chars_sent++;
	endtask

	// Send the characters of s followed by the terminator
	task automatic send_expr(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
		send_char(CHR_NUL);
	endtask

	function automatic logic [7:0] pick_stray_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CHR_PLUS || c == CHR_MINUS || c == CHR_MUL || c == CHR_DIV);
		return c;
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 3))
			0:       return CHR_PLUS;
			1:       return CHR_MINUS;
			2:       return CHR_MUL;
			default: return CHR_DIV;
		endcase
	endfunction

	task automatic send_random_number();
		int n_digits;
		case ($urandom_range(0, 7))
			0:       n_digits = 0;
			1:       n_digits = $urandom_range(4, 11);
			default: n_digits = $urandom_range(1, 3);
		endcase
		if (n_digits == 0)
			send_char(CHR_ZERO);
		repeat (n_digits) begin
			if ($urandom_range(0, 15) == 0)
				send_char(pick_stray_byte());
			else
				send_char(CHR_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	// Mostly well-formed expressions, with broken ones and raw noise mixed in
	task automatic send_random_expression();
		int terms;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(3, 12))
				send_char(8'($urandom_range(0, 255)));
			send_char(CHR_NUL);
		end else begin
			terms = $urandom_range(1, 5);
			if ($urandom_range(0, 7) == 0)
				send_char(pick_operator());
			for (int t = 0; t < terms; t++) begin
				if ($urandom_range(0, 9) != 0)
					send_random_number();
				if (t < terms - 1)
					send_char(pick_operator());
			end
			send_char(CHR_NUL);
		end
	endtask

	task automatic run_random(input int target);
		while (chars_sent < target)
			send_random_expression();
	endtask

	// Take results with random stalls and check each against the oldest expectation
	initial begin
		int      stall;
		result_t want;
		results_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 16) : 0;
			repeat (stall) begin
				results_if.ready <= 1'b0;
				@(posedge clk);
			end
			results_if.ready <= (hold_left == 0);
			@(posedge clk);
			while (!(results_if.valid && results_if.ready)) begin
				results_if.ready <= (hold_left == 0);
				@(posedge clk);
			end
			if (expected_results.size() == 0) begin
				note_error($sformatf("unexpected result: value %0d div_by_zero %0b",
					results_if.value, results_if.div_by_zero));
			end else begin
				want = expected_results.pop_front();
				if (results_if.value !== want.value ||
				    results_if.div_by_zero !== want.div_by_zero)
					note_error($sformatf(
						"mismatch: expected value %0d div_by_zero %0b, got %0d %0b",
						want.value, want.div_by_zero,
						results_if.value, results_if.div_by_zero));
			end
		end
	end

	// Corner expressions: empty, leading operator, truncating division, stray
	// and all-ones bytes, division by zero that sticks, adjacent operators,
	// number wrap and the most negative value divided by minus one
	task automatic test_directed();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_expr("");
		send_expr("-7/2*\377");
		send_expr("4/0+5-*3");
		send_expr("2147483648/.C");
	endtask

	task automatic test_random_with_gaps();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		run_random(600);
	endtask

	task automatic test_random_back_to_back();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		run_random(880);
	endtask

	// Hold results off long enough that the block stops taking characters
	task automatic test_output_stall();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		-> hold_start;
		repeat (10)
			send_random_expression();
	endtask

	task automatic test_random_mixed();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		run_random(1150);
	endtask

	initial begin
		arst_n             <= 1'b0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= '0;
		eval_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_with_gaps();
		test_random_back_to_back();
		test_output_stall();
		test_random_mixed();
		chars_if.valid <= 1'b0;

		// Drain outstanding results, then watch for strays
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
